### rtl/wbps_pkg.sv
// Shared types, constants and helpers for the wildcard byte pattern scanner.
// No dependencies.
`default_nettype none

package wbps_pkg;

    localparam int PATTERN_MAX_DEF  = 16;
    localparam int ADDRESS_BITS_DEF = 32;
    localparam int POS_COUNT        = 16;
    localparam int LEN_CFG_W        = 5;
    localparam int ADDR_W           = 32;
    localparam int CFG_W            = 64;
    localparam int CFG_IDX_W        = 2;
    localparam int QUEUE_DEPTH      = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 2'd0,
        CFG_PATTERN_HIGH = 2'd1,
        CFG_WILDCARD     = 2'd2,
        CFG_LENGTH       = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0]     pattern_low;
        logic [CFG_W-1:0]     pattern_high;
        logic [POS_COUNT-1:0] wildcard_mask;
        logic [LEN_CFG_W-1:0] pattern_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic [ADDR_W-1:0] byte_address;
        logic              first_of_scan;
        logic              last_of_scan;
    } in_word_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } out_word_t;

    typedef struct packed {
        logic                 found;
        logic [ADDR_W-1:0]    byte_address;
        logic [LEN_CFG_W-1:0] len_minus_one;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] pattern_byte(input cfg_t cfg, input logic [3:0] pos);
        logic [2*CFG_W-1:0] both;
        both = {cfg.pattern_high, cfg.pattern_low};
        return both[{pos, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

### rtl/wbps_ifs.sv
// Valid/ready channel interfaces for scan input words and result words.
// Depends on wbps_pkg.
`default_nettype none

interface wbps_in_if
    import wbps_pkg::*;
;
    logic     valid;
    logic     ready;
    in_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface wbps_out_if
    import wbps_pkg::*;
;
    logic      valid;
    logic      ready;
    out_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/wildcard_byte_pattern_scan.sv
// Wildcard byte pattern scanner, top level: config registers, front end, queue, back end.
// A result word goes into the result queue, then into the back-end output register.
// Throughput: one byte per cycle; window shift and masked compare are combinational.
// Input stalls only when the four-entry result queue is full.
// Reset (async, active low): window, counts, queue and output cleared; length reads 1.
// Depends on wbps_pkg, wbps_ifs, wbps_front, wbps_queue and wbps_back.
`default_nettype none

module wildcard_byte_pattern_scan
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX  = PATTERN_MAX_DEF,
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    wbps_in_if.sink                   scan_in,
    wbps_out_if.source                result_out
);

    cfg_t      cfg_reg;
    logic      push, pop;
    q_entry_t  push_entry, pop_entry;
    q_status_t q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_low    <= '0;
            cfg_reg.pattern_high   <= '0;
            cfg_reg.wildcard_mask  <= '0;
            cfg_reg.pattern_length <= LEN_CFG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PATTERN_LOW:  cfg_reg.pattern_low    <= cfg_data;
                CFG_PATTERN_HIGH: cfg_reg.pattern_high   <= cfg_data;
                CFG_WILDCARD:     cfg_reg.wildcard_mask  <= cfg_data[POS_COUNT-1:0];
                CFG_LENGTH:       cfg_reg.pattern_length <= cfg_data[LEN_CFG_W-1:0];
                default:          cfg_reg                <= cfg_reg;
            endcase
        end
    end

    wbps_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .scan_in    (scan_in),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    wbps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    wbps_back #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_entry  (pop_entry),
        .q_status   (q_status),
        .pop        (pop),
        .result_out (result_out)
    );

endmodule

`default_nettype wire

### rtl/wbps_front.sv
// Front end: takes scan words, shifts the byte window, does the masked compare
// and decides results. Depends on wbps_pkg and wbps_ifs.
`default_nettype none

module wbps_front
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    wbps_in_if.sink     scan_in,
    input  wire q_status_t q_status,
    output logic        push,
    output q_entry_t    push_entry
);

    localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int SLOT_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam logic [LEN_CFG_W-1:0] PM_LEN = LEN_CFG_W'(PATTERN_MAX);

    logic [7:0]           window_reg [PATTERN_MAX];
    logic [7:0]           window_next [PATTERN_MAX];
    logic [LEN_W-1:0]     seen_reg, seen_next;
    logic                 done_reg, done_next;
    logic [LEN_CFG_W-1:0] len_eff;
    logic [LEN_CFG_W-1:0] slot;
    logic                 pos_ok;
    logic                 hit;
    logic                 result;
    logic                 accept;
    logic                 done_eff;

    assign scan_in.ready = ~q_status.full;
    assign accept        = scan_in.valid & scan_in.ready;

    always_comb
    begin
        priority if (cfg.pattern_length == '0)
        begin
            len_eff = LEN_CFG_W'(1);
        end
        else if (cfg.pattern_length > PM_LEN)
        begin
            len_eff = PM_LEN;
        end
        else
        begin
            len_eff = cfg.pattern_length;
        end
    end

    always_comb
    begin
        window_next[0] = scan_in.payload.data_byte;
        for (int s = 1; s < PATTERN_MAX; s++)
        begin
            window_next[s] = scan_in.payload.first_of_scan ? 8'h00 : window_reg[s-1];
        end
        if (scan_in.payload.first_of_scan)
        begin
            seen_next = LEN_W'(1);
        end
        else if (seen_reg == LEN_W'(PATTERN_MAX))
        begin
            seen_next = seen_reg;
        end
        else
        begin
            seen_next = seen_reg + LEN_W'(1);
        end
    end

    always_comb
    begin
        pos_ok = 1'b1;
        slot   = '0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if ((LEN_CFG_W'(i) < len_eff) && !cfg.wildcard_mask[i])
            begin
                slot = len_eff - LEN_CFG_W'(1) - LEN_CFG_W'(i);
                if (window_next[slot[SLOT_W-1:0]] != pattern_byte(cfg, 4'(i)))
                begin
                    pos_ok = 1'b0;
                end
            end
        end
        hit = (LEN_CFG_W'(seen_next) >= len_eff) && pos_ok;
    end

    assign done_eff  = scan_in.payload.first_of_scan ? 1'b0 : done_reg;
    assign result    = ~done_eff & (hit | scan_in.payload.last_of_scan);
    assign done_next = done_eff | result;
    assign push      = accept & result;

    assign push_entry.found         = hit;
    assign push_entry.byte_address  = scan_in.payload.byte_address;
    assign push_entry.len_minus_one = len_eff - LEN_CFG_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < PATTERN_MAX; s++)
            begin
                window_reg[s] <= 8'h00;
            end
            seen_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (accept)
        begin
            for (int s = 0; s < PATTERN_MAX; s++)
            begin
                window_reg[s] <= window_next[s];
            end
            seen_reg <= seen_next;
            done_reg <= done_next;
        end
    end

endmodule

`default_nettype wire

### rtl/wbps_queue.sv
// Short result queue between the front end and the back end.
// Depends on wbps_pkg.
`default_nettype none

module wbps_queue
    import wbps_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t push_entry,
    input  wire logic     pop,
    output q_entry_t      pop_entry,
    output q_status_t     status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t         mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push & ~status.full;
    assign do_pop       = pop & ~status.empty;
    assign pop_entry    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/wbps_back.sv
// Back end: forms the match start address and holds the result word for the sink.
// Depends on wbps_pkg and wbps_ifs.
`default_nettype none

module wbps_back
    import wbps_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire q_entry_t  pop_entry,
    input  wire q_status_t q_status,
    output logic           pop,
    wbps_out_if.source     result_out
);

    localparam int KEEP_BITS = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
    localparam logic [ADDR_W-1:0] ADDR_MASK =
        (KEEP_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << KEEP_BITS) - 64'd1);

    logic              valid_reg;
    out_word_t         word_reg;
    out_word_t         word_next;
    logic [ADDR_W-1:0] start;

    assign pop   = ~q_status.empty & (~valid_reg | result_out.ready);
    assign start = (pop_entry.byte_address - ADDR_W'(pop_entry.len_minus_one)) & ADDR_MASK;

    assign word_next.found         = pop_entry.found;
    assign word_next.match_address = pop_entry.found ? start : '0;

    assign result_out.valid   = valid_reg;
    assign result_out.payload = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire
